[hw/rtl/mof_pkg.sv]
package mof_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 14;

    localparam int DEF_GROUP_SIZE  = 3;
    localparam int DEF_GROUP_COUNT = 5;
    localparam int DEF_SAMPLE_BITS = 12;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    typedef logic [SUM_W-1:0] t_sum;

    // handed from one cell to the next
    typedef struct packed {
        logic less;
        t_sum value;
    } t_link;

endpackage

[hw/rtl/mof_cell.sv]
module mof_cell (
    input  logic          i_clk,
    input  logic          i_insert,
    input  logic          i_occupied,
    input  mof_pkg::t_sum i_key,
    input  mof_pkg::t_link i_prev,
    output mof_pkg::t_link o_next,
    output mof_pkg::t_sum o_next_value
);

    mof_pkg::t_sum r_value;
    mof_pkg::t_sum n_value;
    logic          w_less;

    assign w_less = i_occupied && (i_key < r_value);

    always_comb begin
        n_value = r_value;
        if (i_insert && (!i_occupied || w_less)) begin
            n_value = i_prev.less ? i_prev.value : i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_next.less   = w_less;
    assign o_next.value  = r_value;
    assign o_next_value  = n_value;

endmodule

[hw/rtl/median_of_group_averages_filter.sv]
// Median-of-means filter. Each accepted word is a 12-bit converter sample;
// every GROUP_SIZE samples form a group sum (saturated to 14 bits), and after
// GROUP_COUNT groups one word comes out: the median of the group sums
// (upper middle when GROUP_COUNT is even), i.e. GROUP_SIZE times the median
// group mean. One sample is taken per clock; each group sum is registered and
// then placed into a sorted row of GROUP_COUNT insertion cells, and on the
// round's last group the result is latched at the same edge as that insertion.
// Input stalls only while a finished result is held back by a stalled output
// and the next one is ready.
module median_of_group_averages_filter #(
    parameter int GROUP_SIZE  = mof_pkg::DEF_GROUP_SIZE,
    parameter int GROUP_COUNT = mof_pkg::DEF_GROUP_COUNT,
    parameter int SAMPLE_BITS = mof_pkg::DEF_SAMPLE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [mof_pkg::SAMPLE_W-1:0] i_sample,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [mof_pkg::SUM_W-1:0]    o_median_sum
);

    localparam int SizeW  = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
    localparam int CountW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int Mid    = GROUP_COUNT / 2;
    localparam logic [mof_pkg::SAMPLE_W-1:0] SampleMask =
        (SAMPLE_BITS >= mof_pkg::SAMPLE_W) ? '1
                                           : mof_pkg::SAMPLE_W'((1 << SAMPLE_BITS) - 1);
    localparam logic [SizeW-1:0]  LastSample = SizeW'(GROUP_SIZE - 1);
    localparam logic [CountW-1:0] LastGroup  = CountW'(GROUP_COUNT - 1);

    logic [SizeW-1:0]  r_smp_cnt;
    logic [CountW-1:0] r_grp_idx;
    logic [CountW-1:0] r_fill;
    mof_pkg::t_sum     r_acc;
    logic              r_ins_valid;
    logic              r_ins_last;
    mof_pkg::t_sum     r_ins_key;
    logic              r_out_valid;
    mof_pkg::t_sum     r_out_data;

    logic                          w_accept;
    logic                          w_group_done;
    logic                          w_ins_block;
    logic                          w_ins_fire;
    logic [mof_pkg::SUM_W:0]       w_sum_wide;
    mof_pkg::t_sum                 w_sum;
    mof_pkg::t_link                w_link [GROUP_COUNT+1];
    mof_pkg::t_sum                 w_next_value [GROUP_COUNT];

    assign w_ins_block  = r_ins_last && r_out_valid && i_out_stall;
    assign o_in_stall   = r_ins_valid && w_ins_block;
    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_ins_fire   = r_ins_valid && !w_ins_block;
    assign w_group_done = (r_smp_cnt == LastSample);

    assign w_sum_wide = {1'b0, r_acc}
                      + (mof_pkg::SUM_W+1)'(i_sample & SampleMask);
    assign w_sum      = w_sum_wide[mof_pkg::SUM_W] ? mof_pkg::SUM_MAX
                                                   : w_sum_wide[mof_pkg::SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp_cnt   <= '0;
            r_grp_idx   <= '0;
            r_fill      <= '0;
            r_acc       <= '0;
            r_ins_valid <= 1'b0;
            r_ins_last  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                if (w_group_done) begin
                    r_smp_cnt  <= '0;
                    r_acc      <= '0;
                    r_grp_idx  <= (r_grp_idx == LastGroup) ? '0 : r_grp_idx + 1'b1;
                    r_ins_last <= (r_grp_idx == LastGroup);
                end else begin
                    r_smp_cnt <= r_smp_cnt + 1'b1;
                    r_acc     <= w_sum;
                end
            end
            if (w_accept && w_group_done) begin
                r_ins_valid <= 1'b1;
            end else if (w_ins_fire) begin
                r_ins_valid <= 1'b0;
            end
            if (w_ins_fire) begin
                r_fill <= r_ins_last ? '0 : r_fill + 1'b1;
            end
            if (!r_out_valid || !i_out_stall) begin
                r_out_valid <= w_ins_fire && r_ins_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_group_done) begin
            r_ins_key <= w_sum;
        end
        if (w_ins_fire && r_ins_last) begin
            r_out_data <= w_next_value[Mid];
        end
    end

    assign w_link[0] = '0;

    for (genvar gi = 0; gi < GROUP_COUNT; gi++) begin : g_cell
        mof_cell u_cell (
            .i_clk        (i_clk),
            .i_insert     (w_ins_fire),
            .i_occupied   (CountW'(gi) < r_fill),
            .i_key        (r_ins_key),
            .i_prev       (w_link[gi]),
            .o_next       (w_link[gi+1]),
            .o_next_value (w_next_value[gi])
        );
    end

    assign o_out_valid  = r_out_valid;
    assign o_median_sum = r_out_data;

endmodule
